// ===== rtl/core/isort_pkg.sv =====
// Shared types and constants for the insertion sort core.
// No dependencies; compile this file first.
package isort_pkg;

   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // place the key into the sorted row
      logic drain;    // shift the row one place toward cell 0
   } cell_ctrl_type;

endpackage

// ===== rtl/core/isort_chan_if.sv =====
// Valid/ready channel interfaces for the insertion sort core.
// Depends on isort_pkg.
interface isort_req_if import isort_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type value;
   logic      end_of_set;

   modport source (output valid, output value, output end_of_set, input ready);
   modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

interface isort_rsp_if import isort_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type sorted_value;
   logic      last_out;
   logic      overflowed;

   modport source (output valid, output sorted_value, output last_out,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input last_out,
                   input overflowed, output ready);
endinterface

// ===== rtl/core/isort_cell.sv =====
// One compare-and-shift cell of the sorting chain.
// Depends on isort_pkg.
module isort_cell import isort_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  value_type     key,
   input  logic          occupied,
   input  value_type     left_value,
   input  logic          left_greater,
   input  logic          left_occupied,
   input  value_type     right_value,
   output value_type     value,
   output logic          greater
);

   value_type value_ff;
   value_type value_in;

   // Flag an entry that must move up to make room for the key
   assign greater = occupied && (value_ff > key);
   assign value   = value_ff;

   // Take from the left neighbor, take the key, drain from the right, or hold
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (left_greater) begin
            value_in = left_value;
         end else if (left_occupied && (greater || !occupied)) begin
            value_in = key;
         end
      end else if (ctrl.drain) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/core/insertion_sort_ascending_core.sv =====
// Top level of the insertion sort core: cell chain, fill count and emit control.
// Depends on isort_pkg, isort_chan_if and isort_cell.
//
//   Channel   Dir  Handshake        Payload
//   req_chan  in   valid / ready    value, end_of_set
//   rsp_chan  out  valid / ready    sorted_value, last_out, overflowed
//
// Each accepted beat is loaded at once: every cell compares the key and
// the row shifts up in that same cycle. On an end_of_set beat the core stops
// taking beats and streams the set from cell 0, one result per cycle, the row
// draining toward cell 0 on each accepted result; a stalled result holds.
// Synchronous active-high reset clears the fill count, overflow flag and phase.
module insertion_sort_ascending_core import isort_pkg::*; #(
   parameter int MAX_ITEMS = 16
) (
   input logic       clock,
   input logic       reset,
   isort_req_if.sink   req_chan,
   isort_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   localparam logic PH_LOAD = 1'b0;
   localparam logic PH_EMIT = 1'b1;

   logic             phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;

   cell_ctrl_type ctrl;
   logic          req_fire, rsp_fire, full;

   value_type cell_value [MAX_ITEMS];
   logic      cell_greater [MAX_ITEMS];
   logic      cell_occupied [MAX_ITEMS];

   assign full     = (count_ff == CNT_W'(MAX_ITEMS));
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready = (phase_ff == PH_LOAD);

   // Drive the head cell onto the result channel while emitting
   assign rsp_chan.valid        = (phase_ff == PH_EMIT);
   assign rsp_chan.sorted_value = cell_value[0];
   assign rsp_chan.last_out     = (count_ff == CNT_W'(1));
   assign rsp_chan.overflowed   = ovf_ff;

   assign ctrl.insert = req_fire && !full;
   assign ctrl.drain  = rsp_fire;

   // Build the chain; the ends see a fixed neighbor
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      value_type left_value, right_value;
      logic      left_greater, left_occupied;

      assign cell_occupied[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_value    = '0;
         assign left_greater  = 1'b0;
         assign left_occupied = 1'b1;
      end else begin : g_body
         assign left_value    = cell_value[i-1];
         assign left_greater  = cell_greater[i-1];
         assign left_occupied = cell_occupied[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      isort_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .key           (req_chan.value),
         .occupied      (cell_occupied[i]),
         .left_value    (left_value),
         .left_greater  (left_greater),
         .left_occupied (left_occupied),
         .right_value   (right_value),
         .value         (cell_value[i]),
         .greater       (cell_greater[i])
      );
   end

   // Advance fill count, overflow flag and phase
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      case (phase_ff)
         PH_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_chan.end_of_set) begin
                  phase_in = PH_EMIT;
               end
            end
         end
         PH_EMIT: begin
            if (rsp_fire) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  phase_in = PH_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            phase_in = PH_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule
